>>> rtl/eor_pkg.sv
// Shared types and constants for the eight-opcode word machine.
// Used by every module in rtl/ except eor_ram; depends on nothing.
`timescale 1ns / 1ps

package eor_pkg;

  localparam int unsigned MEM_WORDS_DEF = 65536;
  localparam int unsigned REG_COUNT     = 8;
  localparam int unsigned REG_AW        = 3;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned PC_W          = 16;
  localparam int unsigned ADDR_W        = 16;

  // instruction word fields
  localparam int unsigned OPC_LSB = 22;
  localparam int unsigned RA_LSB  = 19;
  localparam int unsigned RB_LSB  = 16;
  localparam int unsigned RD_LSB  = 0;
  localparam int unsigned OFF_W   = 16;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [PC_W-1:0]   pc_t;
  typedef logic [REG_AW-1:0] reg_idx_t;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_EXEC  = 2'd1,
    MODE_RMEM  = 2'd2,
    MODE_RREG  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NAND = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    SRC_TARGET = 2'd0,
    SRC_PC     = 2'd1,
    SRC_EA     = 2'd2
  } addr_src_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MADDR,
    ST_FETCH,
    ST_DECODE,
    ST_RREAD,
    ST_EXEC,
    ST_MEM,
    ST_LOAD,
    ST_RREG,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic      clr_step;
    logic      load_in;
    logic      red_start;
    addr_src_e red_src;
    logic      mem_we;
    logic      mem_re;
    logic      ir_load;
    logic      rf_re;
    logic      commit;
    logic      emit;
  } cmd_t;

  typedef struct packed {
    logic  clr_last;
    logic  red_done;
    logic  halted;
    mode_e mode;
    op_e   op;
  } sts_t;

endpackage

>>> rtl/eight_op_risc_executor.sv
// Eight-opcode word machine: memory write/read, register read, one instruction per item.
// Instruction steps: fetch, decode, register read and execute; lw and sw add a memory step,
// lw a load step; if halted, an item only finishes. Non-power-of-two depths register addresses.
// The next item is taken in the cycle done_o is high; done_o cannot be stalled.
// Reset: a clearing sweep with busy_o high zeroes every memory word.
// Top level; depends on eor_pkg, eor_ctrl and eor_datapath.
`timescale 1ns / 1ps

module eight_op_risc_executor #(
  parameter int unsigned MEMORY_WORDS = eor_pkg::MEM_WORDS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         mode_i,
  input  logic [15:0]        target_address_i,
  input  logic signed [31:0] write_word_i,
  output logic               done_o,
  output logic [15:0]        program_counter_o,
  output logic               is_halted_o,
  output logic [31:0]        executed_total_o,
  output logic [2:0]         executed_opcode_o,
  output logic signed [31:0] read_word_o
);

  eor_pkg::cmd_t  cmd;
  eor_pkg::sts_t  sts;
  eor_pkg::word_t rword;

  eor_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .mode_i (mode_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  eor_datapath #(
    .MEMORY_WORDS(MEMORY_WORDS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (mode_i),
    .target_address_i (target_address_i),
    .write_word_i     (eor_pkg::word_t'(write_word_i)),
    .program_counter_o(program_counter_o),
    .is_halted_o      (is_halted_o),
    .executed_total_o (executed_total_o),
    .executed_opcode_o(executed_opcode_o),
    .read_word_o      (rword),
    .done_o           (done_o)
  );

  assign read_word_o = signed'(rword);

endmodule

>>> rtl/eor_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module eor_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/eor_amod.sv
// Reduces a 16-bit address modulo the memory depth.
// Power-of-two depth: a mask with no delay. Otherwise a two-stage
// reciprocal multiply with one correction step. Uses eor_pkg.
`timescale 1ns / 1ps

module eor_amod #(
  parameter int unsigned MEMORY_WORDS = eor_pkg::MEM_WORDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [eor_pkg::ADDR_W-1:0]      x_i,
  output logic                            done_o,
  output logic [$clog2(MEMORY_WORDS)-1:0] idx_o
);

  localparam int unsigned AW      = $clog2(MEMORY_WORDS);
  localparam bit          IS_POW2 = ((64'd1 << AW) == 64'(MEMORY_WORDS));

  if (IS_POW2) begin : g_mask
    assign idx_o  = x_i[AW-1:0];
    assign done_o = start_i;
  end else begin : g_recip
    localparam int unsigned AX   = eor_pkg::ADDR_W;
    localparam int unsigned PW   = AX + 33;
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(MEMORY_WORDS));
    localparam logic [AX:0] MODV  = (AX + 1)'(MEMORY_WORDS);

    logic          v1_q, v2_q;
    logic [AX-1:0] x1_q;
    logic [PW-1:0] prod_q;
    logic [AW-1:0] idx_q;
    logic [AX:0]   quot;
    logic [2*AX+1:0] qm_full;
    logic [AX:0]   rem, rem_fix;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q <= 1'b0;
        v2_q <= 1'b0;
      end else begin
        v1_q <= start_i;
        v2_q <= v1_q & start_i;
      end
    end

    // quotient estimate is exact or one short; fix the remainder once
    always_comb begin
      quot    = prod_q[32 +: AX + 1];
      qm_full = quot * MODV;
      rem     = {1'b0, x1_q} - qm_full[AX:0];
      rem_fix = (rem >= MODV) ? rem - MODV : rem;
    end

    always_ff @(posedge clk_i) begin
      x1_q   <= x_i;
      prod_q <= PW'(x_i) * PW'(RECIP);
      idx_q  <= rem_fix[AW-1:0];
    end

    assign done_o = v2_q & start_i;
    assign idx_o  = idx_q;
  end

endmodule

>>> rtl/eor_ctrl.sv
// Controller state machine: clearing sweep, item decode and the
// multicycle instruction sequence. Drives eor_pkg::cmd_t to the datapath.
`timescale 1ns / 1ps

module eor_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [1:0]    mode_i,
  input  eor_pkg::sts_t sts_i,
  output eor_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  eor_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= eor_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.red_src = eor_pkg::SRC_TARGET;
    busy_o  = 1'b1;
    case (state_q)
      eor_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = eor_pkg::ST_IDLE;
        end
      end
      eor_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load_in = 1'b1;
          case (eor_pkg::mode_e'(mode_i))
            eor_pkg::MODE_WRITE, eor_pkg::MODE_RMEM: state_d = eor_pkg::ST_MADDR;
            eor_pkg::MODE_EXEC: begin
              state_d = sts_i.halted ? eor_pkg::ST_FINISH : eor_pkg::ST_FETCH;
            end
            default: state_d = eor_pkg::ST_RREG;
          endcase
        end
      end
      eor_pkg::ST_MADDR: begin
        cmd_o.red_start = 1'b1;
        cmd_o.red_src   = eor_pkg::SRC_TARGET;
        if (sts_i.red_done) begin
          if (sts_i.mode == eor_pkg::MODE_WRITE) begin
            cmd_o.mem_we = 1'b1;
            cmd_o.emit   = 1'b1;
            state_d      = eor_pkg::ST_IDLE;
          end else begin
            cmd_o.mem_re = 1'b1;
            state_d      = eor_pkg::ST_FINISH;
          end
        end
      end
      eor_pkg::ST_FETCH: begin
        cmd_o.red_start = 1'b1;
        cmd_o.red_src   = eor_pkg::SRC_PC;
        if (sts_i.red_done) begin
          cmd_o.mem_re = 1'b1;
          state_d      = eor_pkg::ST_DECODE;
        end
      end
      eor_pkg::ST_DECODE: begin
        cmd_o.ir_load = 1'b1;
        state_d       = eor_pkg::ST_RREAD;
      end
      eor_pkg::ST_RREAD: begin
        cmd_o.rf_re = 1'b1;
        state_d     = eor_pkg::ST_EXEC;
      end
      eor_pkg::ST_EXEC: begin
        if (sts_i.op inside {eor_pkg::OP_LW, eor_pkg::OP_SW}) begin
          state_d = eor_pkg::ST_MEM;
        end else begin
          cmd_o.commit = 1'b1;
          cmd_o.emit   = 1'b1;
          state_d      = eor_pkg::ST_IDLE;
        end
      end
      eor_pkg::ST_MEM: begin
        cmd_o.red_start = 1'b1;
        cmd_o.red_src   = eor_pkg::SRC_EA;
        if (sts_i.red_done) begin
          if (sts_i.op == eor_pkg::OP_LW) begin
            cmd_o.mem_re = 1'b1;
            state_d      = eor_pkg::ST_LOAD;
          end else begin
            cmd_o.mem_we = 1'b1;
            cmd_o.commit = 1'b1;
            cmd_o.emit   = 1'b1;
            state_d      = eor_pkg::ST_IDLE;
          end
        end
      end
      eor_pkg::ST_LOAD: begin
        cmd_o.commit = 1'b1;
        cmd_o.emit   = 1'b1;
        state_d      = eor_pkg::ST_IDLE;
      end
      eor_pkg::ST_RREG: begin
        cmd_o.rf_re = 1'b1;
        state_d     = eor_pkg::ST_FINISH;
      end
      eor_pkg::ST_FINISH: begin
        cmd_o.emit = 1'b1;
        state_d    = eor_pkg::ST_IDLE;
      end
      default: begin
        state_d = eor_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/eor_datapath.sv
// Datapath: word memory, duplicated register file, pc, halt flag,
// instruction counter, address reduction and result registers.
// Depends on eor_pkg, eor_ram and eor_amod.
`timescale 1ns / 1ps

module eor_datapath #(
  parameter int unsigned MEMORY_WORDS = eor_pkg::MEM_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  eor_pkg::cmd_t                 cmd_i,
  output eor_pkg::sts_t                 sts_o,
  input  logic [1:0]                    mode_i,
  input  logic [eor_pkg::ADDR_W-1:0]    target_address_i,
  input  eor_pkg::word_t                write_word_i,
  output eor_pkg::pc_t                  program_counter_o,
  output logic                          is_halted_o,
  output eor_pkg::word_t                executed_total_o,
  output logic [2:0]                    executed_opcode_o,
  output eor_pkg::word_t                read_word_o,
  output logic                          done_o
);

  localparam int unsigned AW = $clog2(MEMORY_WORDS);

  // control state
  eor_pkg::pc_t                   pc_q;
  logic                           halted_q;
  eor_pkg::word_t                 cnt_q;
  logic                           done_q;
  logic [AW-1:0]                  clr_q;
  logic [eor_pkg::REG_COUNT-1:0]  vld_q;
  logic                           va_q, vb_q;

  // payload
  eor_pkg::mode_e                 mode_q;
  logic [eor_pkg::ADDR_W-1:0]     target_q;
  eor_pkg::word_t                 wword_q;
  eor_pkg::word_t                 ir_q;
  eor_pkg::word_t                 rword_q;
  logic [2:0]                     opc_q;

  eor_pkg::op_e                   op;
  eor_pkg::reg_idx_t              ra, rb, rd, rf_raddr_a, rf_waddr;
  logic [eor_pkg::OFF_W-1:0]      off;
  eor_pkg::word_t                 a_raw, b_raw, a_val, b_val, rf_wdata, mem_rdata;
  eor_pkg::word_t                 mem_wdata;
  eor_pkg::pc_t                   pc_inc, pc_next;
  logic [eor_pkg::ADDR_W-1:0]     red_x;
  logic [AW-1:0]                  red_idx, mem_waddr;
  logic                           red_done, rf_we, mem_we;

  assign op  = eor_pkg::op_e'(ir_q[eor_pkg::OPC_LSB +: 3]);
  assign ra  = ir_q[eor_pkg::RA_LSB +: eor_pkg::REG_AW];
  assign rb  = ir_q[eor_pkg::RB_LSB +: eor_pkg::REG_AW];
  assign rd  = ir_q[eor_pkg::RD_LSB +: eor_pkg::REG_AW];
  assign off = ir_q[eor_pkg::OFF_W-1:0];

  // entries never written read as zero
  assign a_val = va_q ? a_raw : '0;
  assign b_val = vb_q ? b_raw : '0;

  assign pc_inc = pc_q + eor_pkg::PC_W'(1);

  always_comb begin
    case (cmd_i.red_src)
      eor_pkg::SRC_PC: red_x = pc_q;
      eor_pkg::SRC_EA: red_x = a_val[eor_pkg::ADDR_W-1:0] + off;
      default:         red_x = target_q;
    endcase
  end

  eor_amod #(
    .MEMORY_WORDS(MEMORY_WORDS)
  ) u_amod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.red_start),
    .x_i    (red_x),
    .done_o (red_done),
    .idx_o  (red_idx)
  );

  // word memory: the clearing sweep shares the write port
  assign mem_we    = cmd_i.clr_step | cmd_i.mem_we;
  assign mem_waddr = cmd_i.clr_step ? clr_q : red_idx;
  always_comb begin
    if (cmd_i.clr_step) begin
      mem_wdata = '0;
    end else if (mode_q == eor_pkg::MODE_WRITE) begin
      mem_wdata = wword_q;
    end else begin
      mem_wdata = b_val;
    end
  end

  eor_ram #(
    .WIDTH(eor_pkg::WORD_W),
    .DEPTH(MEMORY_WORDS)
  ) u_wmem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (cmd_i.mem_re),
    .raddr_i(red_idx),
    .rdata_o(mem_rdata)
  );

  // register file write: destination and data follow the opcode
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = rd;
    rf_wdata = ~(a_val & b_val);
    pc_next  = pc_inc;
    case (op)
      eor_pkg::OP_ADD: begin
        rf_we    = 1'b1;
        rf_wdata = a_val + b_val;
      end
      eor_pkg::OP_NAND: begin
        rf_we = 1'b1;
      end
      eor_pkg::OP_LW: begin
        rf_we    = 1'b1;
        rf_waddr = rb;
        rf_wdata = mem_rdata;
      end
      eor_pkg::OP_BEQ: begin
        if (a_val == b_val) begin
          pc_next = pc_inc + off;
        end
      end
      eor_pkg::OP_JALR: begin
        rf_we    = 1'b1;
        rf_waddr = rb;
        rf_wdata = eor_pkg::WORD_W'(pc_inc);
        // link lands first, so a shared register jumps to pc + 1
        pc_next  = (ra == rb) ? pc_inc : a_val[eor_pkg::PC_W-1:0];
      end
      default: begin
      end
    endcase
    rf_we = rf_we & cmd_i.commit;
  end

  assign rf_raddr_a = (mode_q == eor_pkg::MODE_RREG) ?
                      target_q[eor_pkg::REG_AW-1:0] : ra;

  eor_ram #(
    .WIDTH(eor_pkg::WORD_W),
    .DEPTH(eor_pkg::REG_COUNT)
  ) u_rf_a (
    .clk_i  (clk_i),
    .we_i   (rf_we),
    .waddr_i(rf_waddr),
    .wdata_i(rf_wdata),
    .re_i   (cmd_i.rf_re),
    .raddr_i(rf_raddr_a),
    .rdata_o(a_raw)
  );

  eor_ram #(
    .WIDTH(eor_pkg::WORD_W),
    .DEPTH(eor_pkg::REG_COUNT)
  ) u_rf_b (
    .clk_i  (clk_i),
    .we_i   (rf_we),
    .waddr_i(rf_waddr),
    .wdata_i(rf_wdata),
    .re_i   (cmd_i.rf_re),
    .raddr_i(rb),
    .rdata_o(b_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= '0;
      halted_q <= 1'b0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      clr_q    <= '0;
      vld_q    <= '0;
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.rf_re) begin
        va_q <= vld_q[rf_raddr_a];
        vb_q <= vld_q[rb];
      end
      if (rf_we) begin
        vld_q[rf_waddr] <= 1'b1;
      end
      if (cmd_i.commit) begin
        pc_q  <= pc_next;
        cnt_q <= cnt_q + eor_pkg::WORD_W'(1);
        if (op == eor_pkg::OP_HALT) begin
          halted_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q   <= eor_pkg::mode_e'(mode_i);
      target_q <= target_address_i;
      wword_q  <= write_word_i;
    end
    if (cmd_i.ir_load) begin
      ir_q <= mem_rdata;
    end
    if (cmd_i.emit) begin
      opc_q <= cmd_i.commit ? ir_q[eor_pkg::OPC_LSB +: 3] : '0;
      case (mode_q)
        eor_pkg::MODE_RMEM: rword_q <= mem_rdata;
        eor_pkg::MODE_RREG: rword_q <= a_val;
        default:            rword_q <= '0;
      endcase
    end
  end

  assign sts_o.clr_last = (clr_q == AW'(MEMORY_WORDS - 1));
  assign sts_o.red_done = red_done;
  assign sts_o.halted   = halted_q;
  assign sts_o.mode     = mode_q;
  assign sts_o.op       = op;

  assign program_counter_o = pc_q;
  assign is_halted_o       = halted_q;
  assign executed_total_o  = cnt_q;
  assign executed_opcode_o = opc_q;
  assign read_word_o       = rword_q;
  assign done_o            = done_q;

endmodule
